// File: design/assert_macros.svh
// Assertion macros shared by the heap queue RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset
`define IMHQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define IMHQ_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

// File: design/imhq_pkg.sv
// Types and constants of the indexed min-heap queue
`default_nettype none

package imhq_pkg;

  localparam int CAPACITY = 1024;
  localparam int KEY_W    = 32;
  localparam int ID_W     = 10;
  localparam int ID_COUNT = 1 << ID_W;
  localparam int SLOT_W   = $clog2(CAPACITY + 1);
  localparam int HADDR_W  = $clog2(CAPACITY);
  localparam int SIZE_W   = 11;
  localparam int STAT_W   = 3;
  localparam int OP_W     = 2;

  localparam logic [OP_W-1:0] OP_INSERT   = 2'd0;
  localparam logic [OP_W-1:0] OP_EXTRACT  = 2'd1;
  localparam logic [OP_W-1:0] OP_DECREASE = 2'd2;

  localparam logic [STAT_W-1:0] STAT_OK     = 3'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY  = 3'd1;
  localparam logic [STAT_W-1:0] STAT_FULL   = 3'd2;
  localparam logic [STAT_W-1:0] STAT_DUP    = 3'd3;
  localparam logic [STAT_W-1:0] STAT_ABSENT = 3'd4;

  typedef struct packed {
    logic [OP_W-1:0]  operation;
    logic [ID_W-1:0]  item_id;
    logic [KEY_W-1:0] new_key;
  } in_item_t;

  typedef struct packed {
    logic [ID_W-1:0]   min_id;
    logic [KEY_W-1:0]  min_key;
    logic              min_valid;
    logic [SIZE_W-1:0] heap_size;
    logic [STAT_W-1:0] status;
  } out_item_t;

  typedef struct packed {
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] key;
  } entry_t;

endpackage

`default_nettype wire

// File: design/indexed_min_heap_queue_core.sv
// Indexed binary min-heap queue with id position map, sequenced over shared RAM ports
// Operation: insert and decrease sift the entry up, extract moves the last entry to the root
//   and sifts it down, one level per pass through the read and compare states; the block
//   returns to the idle state before it takes the next item.
// Throughput: one item at a time; each level costs a registered heap read and a key compare.
//   A finished result waits in the output register while the next item enters.
// Reset: synchronous, active low; a clearing pass then zeroes the map.
`default_nettype none
`include "assert_macros.svh"

module indexed_min_heap_queue_core (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire                      in_valid,
  output logic                     in_stall,
  input  wire imhq_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire                      out_stall,
  output imhq_pkg::out_item_t      out_data
);
  import imhq_pkg::*;

  // Sequencer states
  localparam logic [3:0] ST_CLR    = 4'd0;
  localparam logic [3:0] ST_IDLE   = 4'd1;
  localparam logic [3:0] ST_CHK    = 4'd2;
  localparam logic [3:0] ST_DCMP   = 4'd3;
  localparam logic [3:0] ST_XROOT  = 4'd4;
  localparam logic [3:0] ST_XLAST  = 4'd5;
  localparam logic [3:0] ST_SU_RD  = 4'd6;
  localparam logic [3:0] ST_SU_CMP = 4'd7;
  localparam logic [3:0] ST_SD_RD  = 4'd8;
  localparam logic [3:0] ST_SD_CMP = 4'd9;
  localparam logic [3:0] ST_PLACE  = 4'd10;
  localparam logic [3:0] ST_FIN_RD = 4'd11;
  localparam logic [3:0] ST_FIN    = 4'd12;

  // Control and working registers
  logic [3:0]        state_r, state_nxt;
  logic [ID_W-1:0]   clr_r, clr_nxt;
  logic [SLOT_W-1:0] cnt_r, cnt_nxt;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic [OP_W-1:0]   op_r, op_nxt;
  logic [ID_W-1:0]   id_r, id_nxt;
  logic [KEY_W-1:0]  key_r, key_nxt;
  entry_t            ent_r, ent_nxt;
  entry_t            root_r, root_nxt;
  logic              have_r, have_nxt;
  logic              right_ok_r, right_ok_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_item_t         out_data_r, out_data_nxt;

  // Heap RAM: one write port, two registered read ports
  entry_t             heap_mem [CAPACITY];
  logic               hw_en, ha_en, hb_en;
  logic [HADDR_W-1:0] hw_addr, ha_addr, hb_addr;
  entry_t             hw_data, ha_q, hb_q;

  // Position map RAM: one write port, one registered read port
  logic [SLOT_W-1:0]  slot_mem [ID_COUNT];
  logic               sw_en, sr_en;
  logic [ID_W-1:0]    sw_addr, sr_addr;
  logic [SLOT_W-1:0]  sw_data, sr_q;

  // Address helpers
  logic [SLOT_W:0]    left_w;
  logic               pick_right;
  entry_t             pick;
  logic [SLOT_W-1:0]  pick_slot;
  logic [SLOT_W-1:0]  parent;
  logic               in_take;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign left_w     = {slot_r, 1'b0};
  assign parent     = slot_r >> 1;
  // Prefer the left child on a tie
  assign pick_right = right_ok_r && (hb_q.key < ha_q.key);
  assign pick       = pick_right ? hb_q : ha_q;
  assign pick_slot  = SLOT_W'(left_w + {{SLOT_W{1'b0}}, pick_right});

  always_ff @(posedge clk) begin
    if (hw_en) begin
      heap_mem[hw_addr] <= hw_data;
    end
    if (ha_en) begin
      ha_q <= heap_mem[ha_addr];
    end
    if (hb_en) begin
      hb_q <= heap_mem[hb_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (sw_en) begin
      slot_mem[sw_addr] <= sw_data;
    end
    if (sr_en) begin
      sr_q <= slot_mem[sr_addr];
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    cnt_nxt       = cnt_r;
    slot_nxt      = slot_r;
    op_nxt        = op_r;
    id_nxt        = id_r;
    key_nxt       = key_r;
    ent_nxt       = ent_r;
    root_nxt      = root_r;
    have_nxt      = have_r;
    right_ok_nxt  = right_ok_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;

    hw_en   = 1'b0;
    hw_addr = HADDR_W'(slot_r - 1'b1);
    hw_data = ent_r;
    ha_en   = 1'b0;
    ha_addr = '0;
    hb_en   = 1'b0;
    hb_addr = '0;
    sw_en   = 1'b0;
    sw_addr = ent_r.id;
    sw_data = slot_r;
    sr_en   = 1'b0;
    sr_addr = in_data.item_id;

    unique case (state_r)
      ST_CLR: begin
        // Sweep the position map to all absent
        sw_en   = 1'b1;
        sw_addr = clr_r;
        sw_data = '0;
        clr_nxt = clr_r + 1'b1;
        if (clr_r == ID_W'(ID_COUNT - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (in_take) begin
          op_nxt     = in_data.operation;
          id_nxt     = in_data.item_id;
          key_nxt    = in_data.new_key;
          have_nxt   = 1'b0;
          status_nxt = STAT_OK;
          priority if (in_data.operation == OP_INSERT) begin
            if (cnt_r >= SLOT_W'(CAPACITY)) begin
              status_nxt = STAT_FULL;
              state_nxt  = ST_FIN_RD;
            end else begin
              sr_en     = 1'b1;
              state_nxt = ST_CHK;
            end
          end else if (in_data.operation == OP_EXTRACT) begin
            if (cnt_r == '0) begin
              status_nxt = STAT_EMPTY;
              state_nxt  = ST_FIN_RD;
            end else begin
              ha_en     = 1'b1;
              ha_addr   = '0;
              state_nxt = ST_XROOT;
            end
          end else if (in_data.operation == OP_DECREASE) begin
            sr_en     = 1'b1;
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_FIN_RD;
          end
        end
      end

      ST_CHK: begin
        // Position map data is valid here
        if (op_r == OP_INSERT) begin
          if (sr_q != '0) begin
            status_nxt = STAT_DUP;
            state_nxt  = ST_FIN_RD;
          end else begin
            cnt_nxt     = cnt_r + 1'b1;
            slot_nxt    = cnt_r + 1'b1;
            ent_nxt.id  = id_r;
            ent_nxt.key = key_r;
            state_nxt   = ST_SU_RD;
          end
        end else begin
          if (sr_q == '0 || sr_q > cnt_r) begin
            status_nxt = STAT_ABSENT;
            state_nxt  = ST_FIN_RD;
          end else begin
            slot_nxt  = sr_q;
            ha_en     = 1'b1;
            ha_addr   = HADDR_W'(sr_q - 1'b1);
            state_nxt = ST_DCMP;
          end
        end
      end

      ST_DCMP: begin
        if (!(key_r < ha_q.key)) begin
          status_nxt = STAT_ABSENT;
          state_nxt  = ST_FIN_RD;
        end else begin
          ent_nxt.id  = ha_q.id;
          ent_nxt.key = key_r;
          state_nxt   = ST_SU_RD;
        end
      end

      ST_XROOT: begin
        // Capture the root, drop its id from the map, fetch the last entry
        root_nxt  = ha_q;
        have_nxt  = 1'b1;
        sw_en     = 1'b1;
        sw_addr   = ha_q.id;
        sw_data   = '0;
        ha_en     = 1'b1;
        ha_addr   = HADDR_W'(cnt_r - 1'b1);
        cnt_nxt   = cnt_r - 1'b1;
        state_nxt = ST_XLAST;
      end

      ST_XLAST: begin
        if (cnt_r != '0) begin
          ent_nxt   = ha_q;
          slot_nxt  = SLOT_W'(1);
          state_nxt = ST_SD_RD;
        end else begin
          state_nxt = ST_FIN_RD;
        end
      end

      ST_SU_RD: begin
        if (slot_r > SLOT_W'(1)) begin
          ha_en     = 1'b1;
          ha_addr   = HADDR_W'(parent - 1'b1);
          state_nxt = ST_SU_CMP;
        end else begin
          state_nxt = ST_PLACE;
        end
      end

      ST_SU_CMP: begin
        if (ha_q.key > ent_r.key) begin
          // Move the parent down one level
          hw_en     = 1'b1;
          hw_data   = ha_q;
          sw_en     = 1'b1;
          sw_addr   = ha_q.id;
          slot_nxt  = parent;
          state_nxt = ST_SU_RD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end

      ST_SD_RD: begin
        if (left_w > {1'b0, cnt_r}) begin
          state_nxt = ST_PLACE;
        end else begin
          ha_en        = 1'b1;
          ha_addr      = HADDR_W'(left_w - 1'b1);
          hb_en        = 1'b1;
          hb_addr      = HADDR_W'(left_w);
          right_ok_nxt = (left_w < {1'b0, cnt_r});
          state_nxt    = ST_SD_CMP;
        end
      end

      ST_SD_CMP: begin
        if (ent_r.key > pick.key) begin
          // Move the smaller child up one level
          hw_en     = 1'b1;
          hw_data   = pick;
          sw_en     = 1'b1;
          sw_addr   = pick.id;
          slot_nxt  = pick_slot;
          state_nxt = ST_SD_RD;
        end else begin
          state_nxt = ST_PLACE;
        end
      end

      ST_PLACE: begin
        hw_en     = 1'b1;
        sw_en     = 1'b1;
        state_nxt = ST_FIN_RD;
      end

      ST_FIN_RD: begin
        if (!have_r && cnt_r != '0) begin
          ha_en   = 1'b1;
          ha_addr = '0;
        end
        state_nxt = ST_FIN;
      end

      ST_FIN: begin
        // Hold until the output register is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.heap_size = SIZE_W'(cnt_r);
          out_data_nxt.status    = status_r;
          if (have_r) begin
            out_data_nxt.min_id    = root_r.id;
            out_data_nxt.min_key   = root_r.key;
            out_data_nxt.min_valid = 1'b1;
          end else if (cnt_r != '0) begin
            out_data_nxt.min_id    = ha_q.id;
            out_data_nxt.min_key   = ha_q.key;
            out_data_nxt.min_valid = 1'b1;
          end else begin
            out_data_nxt.min_id    = '0;
            out_data_nxt.min_key   = '0;
            out_data_nxt.min_valid = 1'b0;
          end
          state_nxt = ST_IDLE;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLR;
      clr_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r     <= slot_nxt;
    op_r       <= op_nxt;
    id_r       <= id_nxt;
    key_r      <= key_nxt;
    ent_r      <= ent_nxt;
    root_r     <= root_nxt;
    have_r     <= have_nxt;
    right_ok_r <= right_ok_nxt;
    status_r   <= status_nxt;
    out_data_r <= out_data_nxt;
  end

  `IMHQ_ASSERT(a_cnt_bound, cnt_r <= SLOT_W'(CAPACITY), "entry count beyond capacity")
  `IMHQ_ASSERT_IMPL(a_cursor_in_heap, state_r == ST_SU_RD || state_r == ST_SD_RD || state_r == ST_PLACE, slot_r != '0 && slot_r <= cnt_r, "sift cursor outside the heap")
  `IMHQ_ASSERT_IMPL(a_cnt_step, state_r != ST_CLR && cnt_r != $past(cnt_r), cnt_r == $past(cnt_r) + 1'b1 || cnt_r == $past(cnt_r) - 1'b1, "entry count moved by more than one")
  `IMHQ_ASSERT_IMPL(a_empty_result, out_valid && out_data.status == STAT_EMPTY, out_data.heap_size == '0 && !out_data.min_valid, "empty status with entries reported")
  `IMHQ_ASSERT_IMPL(a_invalid_zero, out_valid && !out_data.min_valid, out_data.min_id == '0 && out_data.min_key == '0, "invalid minimum carries data")

endmodule

`default_nettype wire

// File: test/imhq_checker.sv
// Scoreboard for the indexed min-heap queue: mirrors the heap and checks every result item
`timescale 1ns / 1ps

module imhq_checker (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  input  wire                 in_stall,
  input  imhq_pkg::in_item_t  in_data,
  input  wire                 out_valid,
  input  wire                 out_stall,
  input  imhq_pkg::out_item_t out_data,
  output int                  fail_count,
  output int                  awaiting
);
  import imhq_pkg::*;

  // Shadow heap: slots 1..fill hold live entries, slot_of maps id to slot (0 = absent)
  logic [ID_W-1:0]   heap_ids_q  [1:CAPACITY];
  logic [KEY_W-1:0]  heap_keys_q [1:CAPACITY];
  logic [SLOT_W-1:0] slot_of     [ID_COUNT];
  int unsigned       fill;

  out_item_t heap_replies_due [$];

  task automatic note_mismatch(input string field, input logic [31:0] got,
                               input logic [31:0] want);
    $display("%0t mismatch on %s: got %0h, want %0h", $realtime, field, got, want);
    fail_count++;
  endtask

  function automatic void put(input int unsigned s, input logic [ID_W-1:0] id,
                              input logic [KEY_W-1:0] k);
    heap_ids_q[s]  = id;
    heap_keys_q[s] = k;
    slot_of[id]    = SLOT_W'(s);
  endfunction

  function automatic void rise(input int unsigned start);
    int unsigned      s;
    logic [ID_W-1:0]  id;
    logic [KEY_W-1:0] k;
    s  = start;
    id = heap_ids_q[s];
    k  = heap_keys_q[s];
    while (s > 1 && heap_keys_q[s / 2] > k) begin
      put(s, heap_ids_q[s / 2], heap_keys_q[s / 2]);
      s = s / 2;
    end
    put(s, id, k);
  endfunction

  function automatic void sink(input int unsigned start);
    int unsigned      s;
    int unsigned      l;
    int unsigned      p;
    logic [ID_W-1:0]  tid;
    logic [KEY_W-1:0] tk;
    bit               done;
    s    = start;
    done = 1'b0;
    while (!done) begin
      l = 2 * s;
      if (l > fill) begin
        done = 1'b1;
      end else begin
        p = l;
        // equal children: stay with the left one
        if (l + 1 <= fill && heap_keys_q[l + 1] < heap_keys_q[l]) p = l + 1;
        if (heap_keys_q[s] > heap_keys_q[p]) begin
          tid = heap_ids_q[s];
          tk  = heap_keys_q[s];
          put(s, heap_ids_q[p], heap_keys_q[p]);
          put(p, tid, tk);
          s = p;
        end else begin
          done = 1'b1;
        end
      end
    end
  endfunction

  function automatic out_item_t predict_heap_op(input in_item_t it);
    out_item_t   r;
    int unsigned s;
    int unsigned last;
    bit          have;
    r        = '0;
    r.status = STAT_OK;
    have     = 1'b0;
    case (it.operation)
      OP_INSERT: begin
        if (fill >= CAPACITY) begin
          r.status = STAT_FULL;
        end else if (slot_of[it.item_id] != 0) begin
          r.status = STAT_DUP;
        end else begin
          fill++;
          put(fill, it.item_id, it.new_key);
          rise(fill);
        end
      end
      OP_EXTRACT: begin
        if (fill == 0) begin
          r.status = STAT_EMPTY;
        end else begin
          last      = fill;
          r.min_id  = heap_ids_q[1];
          r.min_key = heap_keys_q[1];
          have      = 1'b1;
          slot_of[heap_ids_q[1]] = '0;
          fill--;
          if (last > 1) begin
            put(1, heap_ids_q[last], heap_keys_q[last]);
            sink(1);
          end
        end
      end
      OP_DECREASE: begin
        s = slot_of[it.item_id];
        if (s == 0 || s > fill || !(it.new_key < heap_keys_q[s])) begin
          r.status = STAT_ABSENT;
        end else begin
          heap_keys_q[s] = it.new_key;
          rise(s);
        end
      end
      default: ;
    endcase
    if (!have && fill > 0) begin
      r.min_id  = heap_ids_q[1];
      r.min_key = heap_keys_q[1];
      have      = 1'b1;
    end
    r.min_valid = have;
    r.heap_size = SIZE_W'(fill);
    return r;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      for (int i = 0; i < ID_COUNT; i++) slot_of[i] = '0;
      fill = 0;
      heap_replies_due.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (heap_replies_due.size() == 0) begin
          note_mismatch("unexpected result", out_data.min_id, '0);
        end else begin
          want = heap_replies_due.pop_front();
          if (out_data.min_id !== want.min_id)
            note_mismatch("min_id", out_data.min_id, want.min_id);
          if (out_data.min_key !== want.min_key)
            note_mismatch("min_key", out_data.min_key, want.min_key);
          if (out_data.min_valid !== want.min_valid)
            note_mismatch("min_valid", out_data.min_valid, want.min_valid);
          if (out_data.heap_size !== want.heap_size)
            note_mismatch("heap_size", out_data.heap_size, want.heap_size);
          if (out_data.status !== want.status)
            note_mismatch("status", out_data.status, want.status);
        end
      end
      if (in_valid && !in_stall)
        heap_replies_due.push_back(predict_heap_op(in_data));
    end
    awaiting = heap_replies_due.size();
  end

endmodule

// File: test/tb.sv
// Testbench top for the indexed min-heap queue: clock, reset, stimulus and verdict
`timescale 1ns / 1ps

module tb;
  import imhq_pkg::*;

  // The block ignores this code; it only reports the root
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
  // Generous ceiling on the length of a clean run
  localparam int CYCLE_LIMIT = 250_000;
  localparam int RANDOM_ITEMS = 680;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;

  int fail_count;
  int awaiting;
  int cycles;

  // Idling controls: quiet gives stretches with no gaps, calm switches idling off for the tail
  bit quiet;
  bit calm;

  indexed_min_heap_queue_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  imhq_checker u_scoreboard (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .fail_count (fail_count),
    .awaiting   (awaiting)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog: stop the run if the block hangs or loses a result item
  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("[indexed_min_heap_queue_core] ERROR");
    $finish;
  end

  // Result side: stall in random bursts, changing only at the falling edge
  initial begin
    int n;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (!calm && !quiet && $urandom_range(0, 5) == 0) begin
        n = $urandom_range(1, 14);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Mix of key shapes: full range, a narrow band for ties, and the two extremes
  function automatic logic [KEY_W-1:0] draw_key();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 6) return $urandom;
    if (pick < 8) return KEY_W'($urandom_range(0, 15));
    if (pick < 9) return '0;
    return '1;
  endfunction

  // Present one item from a falling edge and hold it until the block takes it
  task automatic send_item(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [KEY_W-1:0] k);
    in_item_t it;
    int       gap;
    it.operation = op;
    it.item_id   = id;
    it.new_key   = k;
    if ($urandom_range(0, 39) == 0) quiet = !quiet;
    if (!calm && !quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 14);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  initial begin
    int                  n;
    int                  pick;
    logic [OP_W-1:0]     op;
    logic [ID_W-1:0]     id;
    logic [KEY_W-1:0]    k;

    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    quiet    = 1'b0;
    calm     = 1'b0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-heap cases first
    send_item(OP_EXTRACT, 10'd0, '0);
    send_item(OP_DECREASE, 10'd3, 32'd1);
    send_item(OP_UNUSED, 10'd1023, '1);
    // Field extremes and a tie with the root that must not move anything
    send_item(OP_INSERT, 10'd0, 32'hFFFF_FFFF);
    send_item(OP_INSERT, 10'd1023, 32'h0000_0000);
    send_item(OP_INSERT, 10'd5, 32'h0000_0000);
    send_item(OP_INSERT, 10'd1023, 32'd7);
    // Decrease: equal key refused, smaller key taken, absent id refused
    send_item(OP_DECREASE, 10'd0, 32'hFFFF_FFFF);
    send_item(OP_DECREASE, 10'd0, 32'hFFFF_FFFE);
    send_item(OP_DECREASE, 10'd5, 32'h0000_0000);
    send_item(OP_DECREASE, 10'd7, 32'd3);
    // Equal children: sift-down has to go left
    send_item(OP_INSERT, 10'd8, 32'd10);
    send_item(OP_INSERT, 10'd9, 32'd10);
    send_item(OP_UNUSED, 10'd2, 32'd4);
    send_item(OP_DECREASE, 10'd9, 32'd0);
    // Drain past empty
    repeat (7) send_item(OP_EXTRACT, 10'd0, '0);
    send_item(OP_DECREASE, 10'd9, 32'd0);

    // Random mix: mostly ids from a small pool so duplicates and decreases hit live entries
    for (n = 0; n < RANDOM_ITEMS; n++) begin
      // drop idling for the tail
      if (n == RANDOM_ITEMS - 120) calm = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 48)      op = OP_INSERT;
      else if (pick < 73) op = OP_EXTRACT;
      else if (pick < 95) op = OP_DECREASE;
      else                op = OP_UNUSED;
      id = ($urandom_range(0, 3) == 0) ? ID_W'($urandom_range(0, ID_COUNT - 1))
                                       : ID_W'($urandom_range(0, 127));
      k = draw_key();
      // lowered keys are usually below the stored one
      if (op == OP_DECREASE) k = k >> $urandom_range(0, 31);
      send_item(op, id, k);
    end

    in_valid <= 1'b0;
    // Wait for the last result item, then allow a short settle for stray outputs
    while (awaiting != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (fail_count == 0) begin
      $display("[indexed_min_heap_queue_core] OK");
    end else begin
      $display("[indexed_min_heap_queue_core] ERROR");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+design
design/imhq_pkg.sv
design/indexed_min_heap_queue_core.sv
test/imhq_checker.sv
test/tb.sv
